/* rtl/cbs_pkg.sv */
// Package for the cluster block sum engine: sizes, command and status codes,
// item and result payloads, and the controller/datapath handshake structs.
// No dependencies.
package cbs_pkg;

	// Sizing
	localparam int MAX_NODES    = 4096;
	localparam int MAX_CLUSTERS = 64;
	localparam int SUM_WIDTH    = 48;

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int CLU_W  = $clog2(MAX_CLUSTERS);
	localparam int CELL_W = 2 * CLU_W;

	// Fixed field widths of the item and result payloads
	localparam int NODE_FW  = 12;
	localparam int LABEL_FW = 6;
	localparam int WEIGHT_W = 16;
	localparam int OUT_W    = 48;
	localparam int CNT_W    = 7;

	// Configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic REG_CLUSTER_COUNT = 1'b0;
	localparam logic REG_BIPARTITE     = 1'b1;
	localparam logic [CNT_W-1:0] CLUSTER_COUNT_RST = CNT_W'(64);

	typedef enum logic [1:0] {
		CMD_SET_LABEL = 2'd0,
		CMD_ADD       = 2'd1,
		CMD_READ      = 2'd2,
		CMD_CLEAR     = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_LABEL = 2'd1,
		ST_BAD_READ  = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]          command;
		logic [NODE_FW-1:0]  node_row;
		logic [NODE_FW-1:0]  node_col;
		logic                label_side;
		logic [LABEL_FW-1:0] label_value;
		logic [WEIGHT_W-1:0] weight;
		logic [LABEL_FW-1:0] cluster_row;
		logic [LABEL_FW-1:0] cluster_col;
	} item_t;

	typedef struct packed {
		logic [OUT_W-1:0] cell_sum;
		logic             saturated;
		logic [1:0]       status;
	} result_t;

	// Controller to datapath
	typedef struct packed {
		logic latch;       // capture accepted item
		logic label_step;  // read label tables, write label on set
		logic cell_rd;     // range check, issue sum store read
		logic cell_upd;    // update cell, form result
		logic clr_wr;      // zero one cell, advance sweep
		logic clr_done;    // form the clear result
		logic emit;        // load output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [1:0] command;
		logic       clr_last;
		logic       out_free;
	} dp_stat_t;

endpackage

/* rtl/cbs_if.sv */
// Valid/ready channel interfaces for items and results.
// Depends on cbs_pkg.
interface cbs_item_if
	import cbs_pkg::*;
	();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cbs_result_if
	import cbs_pkg::*;
	();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/cbs_regs.sv */
// APB-style configuration registers: cluster count and bipartite mode.
// Depends on cbs_pkg.
module cbs_regs
	import cbs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output logic [CNT_W-1:0]   cluster_count,
	output logic               bipartite
);

	logic [CNT_W-1:0] cluster_count_q;
	logic             bipartite_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	// Register writes, decoded on the word address bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_count_q <= CLUSTER_COUNT_RST;
			bipartite_q     <= 1'b0;
		end else if (wr_en) begin
			if (paddr[2] == REG_CLUSTER_COUNT) begin
				cluster_count_q <= pwdata[CNT_W-1:0];
			end else begin
				bipartite_q <= pwdata[0];
			end
		end
	end

	// Read back
	always_comb begin
		if (paddr[2] == REG_CLUSTER_COUNT) begin
			prdata = PDATA_W'(cluster_count_q);
		end else begin
			prdata = PDATA_W'(bipartite_q);
		end
	end

	assign cluster_count = cluster_count_q;
	assign bipartite     = bipartite_q;

endmodule

/* rtl/cbs_ctrl.sv */
// Controller for the cluster block sum engine: sequences one item at a time
// through label lookup, then cell read and update or a clear sweep (neither for set label), and emit.
// Depends on cbs_pkg.
module cbs_ctrl
	import cbs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_LABEL,
		S_CELL_RD,
		S_CELL_UPD,
		S_CLEAR,
		S_EMIT
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	// Commands decoded from state
	always_comb begin
		cmd            = '0;
		cmd.latch      = (state_q == S_IDLE) & in_valid;
		cmd.label_step = (state_q == S_LABEL);
		cmd.cell_rd    = (state_q == S_CELL_RD);
		cmd.cell_upd   = (state_q == S_CELL_UPD);
		cmd.clr_wr     = (state_q == S_CLEAR) | (state_q == S_INIT);
		cmd.clr_done   = (state_q == S_CLEAR) & stat.clr_last;
		cmd.emit       = (state_q == S_EMIT) & stat.out_free;
	end

	// State register; reset starts the sum store clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			unique case (state_q)
				S_INIT: begin
					if (stat.clr_last) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (in_valid) state_q <= S_LABEL;
				end
				S_LABEL: begin
					unique case (cmd_t'(stat.command))
						CMD_SET_LABEL: state_q <= S_EMIT;
						CMD_ADD:       state_q <= S_CELL_RD;
						CMD_READ:      state_q <= S_CELL_RD;
						CMD_CLEAR:     state_q <= S_CLEAR;
						default:       state_q <= S_EMIT;
					endcase
				end
				S_CELL_RD:  state_q <= S_CELL_UPD;
				S_CELL_UPD: state_q <= S_EMIT;
				S_CLEAR: begin
					if (stat.clr_last) state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (stat.out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/cbs_dp.sv */
// Datapath for the cluster block sum engine: label tables, sum store,
// saturating adder, range checks and the output register.
// Depends on cbs_pkg.
module cbs_dp
	import cbs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  dp_cmd_t          cmd,
	output dp_stat_t         stat,
	input  item_t            in_data,
	input  logic [CNT_W-1:0] cluster_count,
	input  logic             bipartite,
	output logic             out_valid,
	input  logic             out_ready,
	output result_t          out_data
);

	localparam logic [SUM_WIDTH-1:0] FULL_SCALE = '1;

	// Memories
	logic [CLU_W-1:0]     row_mem [MAX_NODES];
	logic [CLU_W-1:0]     col_mem [MAX_NODES];
	logic [SUM_WIDTH-1:0] sum_mem [MAX_CLUSTERS * MAX_CLUSTERS];

	item_t                item_q;
	logic [CLU_W-1:0]     lr_q;
	logic [CLU_W-1:0]     lc_row_q;
	logic [CLU_W-1:0]     lc_col_q;
	logic [CELL_W-1:0]    cell_addr_q;
	logic                 rej_q;
	logic [SUM_WIDTH-1:0] sum_rd_q;
	logic [CELL_W-1:0]    clr_addr_q;
	result_t              res_q;
	logic                 out_valid_q;
	result_t              out_data_q;

	logic [NODE_W-1:0]    nr;
	logic [NODE_W-1:0]    nc;
	logic [CLU_W-1:0]     lab;
	logic                 lab_ok;
	logic [CLU_W-1:0]     lc;
	logic [CLU_W-1:0]     row_sel;
	logic [CLU_W-1:0]     col_sel;
	logic                 is_add;
	logic [SUM_WIDTH:0]   sum_ext;
	logic [SUM_WIDTH-1:0] sum_new;
	logic                 mem_we;
	logic [CELL_W-1:0]    mem_waddr;
	logic [SUM_WIDTH-1:0] mem_wdata;

	assign nr     = item_q.node_row[NODE_W-1:0];
	assign nc     = item_q.node_col[NODE_W-1:0];
	assign lab    = item_q.label_value[CLU_W-1:0];
	assign lab_ok = CNT_W'(lab) < cluster_count;
	assign is_add = (cmd_t'(item_q.command) == CMD_ADD);

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.latch) item_q <= in_data;
	end

	// Label tables: set-label write, lookups for add
	always_ff @(posedge clk) begin
		if (cmd.label_step) begin
			if ((cmd_t'(item_q.command) == CMD_SET_LABEL) && lab_ok) begin
				if (item_q.label_side) begin
					col_mem[nr] <= lab;
				end else begin
					row_mem[nr] <= lab;
				end
			end
			lr_q     <= row_mem[nr];
			lc_row_q <= row_mem[nc];
			lc_col_q <= col_mem[nc];
		end
	end

	// Cell address and range check
	assign lc      = bipartite ? lc_col_q : lc_row_q;
	assign row_sel = is_add ? lr_q : item_q.cluster_row[CLU_W-1:0];
	assign col_sel = is_add ? lc : item_q.cluster_col[CLU_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.cell_rd) begin
			cell_addr_q <= {row_sel, col_sel};
			rej_q       <= (CNT_W'(row_sel) >= cluster_count) |
			               (CNT_W'(col_sel) >= cluster_count);
			sum_rd_q    <= sum_mem[{row_sel, col_sel}];
		end
	end

	// Saturating add
	assign sum_ext = {1'b0, sum_rd_q} + (SUM_WIDTH + 1)'(item_q.weight);
	assign sum_new = sum_ext[SUM_WIDTH] ? FULL_SCALE : sum_ext[SUM_WIDTH-1:0];

	// Sum store write port: clearing sweep or cell update
	assign mem_we    = cmd.clr_wr | (cmd.cell_upd & is_add & ~rej_q);
	assign mem_waddr = cmd.clr_wr ? clr_addr_q : cell_addr_q;
	assign mem_wdata = cmd.clr_wr ? '0 : sum_new;

	always_ff @(posedge clk) begin
		if (mem_we) sum_mem[mem_waddr] <= mem_wdata;
	end

	// Clearing sweep address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Pending result
	always_ff @(posedge clk) begin
		if (cmd.label_step) begin
			res_q.cell_sum  <= '0;
			res_q.saturated <= 1'b0;
			res_q.status    <= lab_ok ? ST_OK : ST_BAD_LABEL;
		end else if (cmd.cell_upd) begin
			if (rej_q) begin
				res_q.cell_sum  <= '0;
				res_q.saturated <= 1'b0;
				res_q.status    <= is_add ? ST_BAD_LABEL : ST_BAD_READ;
			end else if (is_add) begin
				res_q.cell_sum  <= OUT_W'(sum_new);
				res_q.saturated <= (sum_new == FULL_SCALE);
				res_q.status    <= ST_OK;
			end else begin
				res_q.cell_sum  <= OUT_W'(sum_rd_q);
				res_q.saturated <= (sum_rd_q == FULL_SCALE);
				res_q.status    <= ST_OK;
			end
		end else if (cmd.clr_done) begin
			res_q <= '0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) out_data_q <= res_q;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Status to controller
	assign stat.command  = item_q.command;
	assign stat.clr_last = &clr_addr_q;
	assign stat.out_free = ~out_valid_q | out_ready;

endmodule

/* rtl/cluster_block_sum.sv */
// cluster_block_sum: one item in flight. Each item steps through label lookup,
// then cell read and update (add, read) or a sweep of every sum store cell (clear).
// The next item is taken the cycle after its result is loaded, so no item is taken
// before the last result is loaded, and a stalled result output holds items off.
// Reset is asynchronous; afterwards a sweep zeroes every cell of the sum store
// with items held off; configuration writes are taken throughout.
module cluster_block_sum
	import cbs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	cbs_item_if.sink           items,
	cbs_result_if.source       results,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	logic [CNT_W-1:0] cluster_count;
	logic             bipartite;
	dp_cmd_t          cmd;
	dp_stat_t         stat;

	// Configuration registers
	cbs_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.cluster_count (cluster_count),
		.bipartite     (bipartite)
	);

	// Controller
	cbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath
	cbs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.in_data       (items.data),
		.cluster_count (cluster_count),
		.bipartite     (bipartite),
		.out_valid     (results.valid),
		.out_ready     (results.ready),
		.out_data      (results.data)
	);

endmodule

/* tb/testbench.sv */
// Self-checking testbench for cluster_block_sum: drives label, add, read and clear
// transfers, predicts every result in its own block sum model, compares per field.
// Depends on cbs_pkg, the cbs_item_if/cbs_result_if interfaces and the RTL top.
`timescale 1ns / 100ps

module testbench;
	import cbs_pkg::*;

	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 165;
	localparam int POOL_SIZE   = 24;
	localparam int HOLD_AT     = 1100;
	localparam int HOLD_CYCLES = 400;
	localparam int MAX_PRINTS  = 20;
	localparam logic [SUM_WIDTH-1:0] FULL_SCALE = '1;

	typedef enum logic [1:0] {
		IDLE_RX_HEAVY,
		IDLE_TX_HEAVY,
		IDLE_NONE
	} idle_mode_t;

	// Clock, reset and driven inputs, all known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	item_t item_data = '0;
	logic result_ready = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic pready;

	cbs_item_if item_ch();
	cbs_result_if result_ch();

	assign item_ch.valid = item_valid;
	assign item_ch.data = item_data;
	assign result_ch.ready = result_ready;

	cluster_block_sum u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (item_ch),
		.results (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #2 clk = ~clk;

	// Predictor state: label tables, cell sums and register copies
	logic [LABEL_FW-1:0] row_labels [MAX_NODES];
	logic [LABEL_FW-1:0] col_labels [MAX_NODES];
	logic [SUM_WIDTH-1:0] cell_sums [MAX_CLUSTERS*MAX_CLUSTERS];
	logic [CNT_W-1:0] cfg_count = CLUSTER_COUNT_RST;
	logic cfg_bip = 1'b0;

	item_t pending_items [$];
	result_t predicted_results [$];

	// Generation-side view of which labels exist (-1: never written)
	int gen_row_lab [MAX_NODES];
	int gen_col_lab [MAX_NODES];
	int row_known [$];
	int col_known [$];
	int node_pool [$];

	idle_mode_t idle_mode = IDLE_RX_HEAVY;
	int accepted_count = 0;
	int hold_left = 0;
	logic hold_used = 1'b0;
	int mismatches = 0;
	int results_seen = 0;
	int command_seen [4];
	int status_seen [4];
	logic [SUM_WIDTH-1:0] peak_sum = '0;

	function automatic int active_clusters();
		return (cfg_count > MAX_CLUSTERS) ? MAX_CLUSTERS : int'(cfg_count);
	endfunction

	// Applies one accepted transfer to the predicted state, returns its result
	function automatic result_t apply_to_block_sums(item_t it);
		result_t res;
		int k;
		logic [LABEL_FW-1:0] lr;
		logic [LABEL_FW-1:0] lc;
		logic [CELL_W-1:0] cell_idx;
		logic [SUM_WIDTH:0] total;
		res = '0;
		res.status = ST_OK;
		k = active_clusters();
		case (it.command)
		CMD_SET_LABEL: begin
			if (it.label_value >= k)
				res.status = ST_BAD_LABEL;
			else if (it.label_side)
				col_labels[it.node_row] = it.label_value;
			else
				row_labels[it.node_row] = it.label_value;
		end
		CMD_ADD: begin
			lr = row_labels[it.node_row];
			lc = cfg_bip ? col_labels[it.node_col] : row_labels[it.node_col];
			if (lr >= k || lc >= k) begin
				res.status = ST_BAD_LABEL;
			end else begin
				cell_idx = {lr, lc};
				total = cell_sums[cell_idx] + it.weight;
				cell_sums[cell_idx] = (total > FULL_SCALE) ? FULL_SCALE :
					total[SUM_WIDTH-1:0];
				res.cell_sum = cell_sums[cell_idx];
				res.saturated = (cell_sums[cell_idx] == FULL_SCALE);
			end
		end
		CMD_READ: begin
			if (it.cluster_row >= k || it.cluster_col >= k) begin
				res.status = ST_BAD_READ;
			end else begin
				cell_idx = {it.cluster_row, it.cluster_col};
				res.cell_sum = cell_sums[cell_idx];
				res.saturated = (cell_sums[cell_idx] == FULL_SCALE);
			end
		end
		default: begin
			foreach (cell_sums[i])
				cell_sums[i] = '0;
		end
		endcase
		return res;
	endfunction

	// Unused fields of every item carry random bits
	function automatic item_t random_item_bits();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return item_t'(raw[$bits(item_t)-1:0]);
	endfunction

	task automatic queue_label(int node, bit side, int lab);
		item_t it;
		it = random_item_bits();
		it.command = CMD_SET_LABEL;
		it.node_row = NODE_FW'(node);
		it.label_side = side;
		it.label_value = LABEL_FW'(lab);
		// track labels that will really land in a table
		if (lab < active_clusters()) begin
			if (side) begin
				if (gen_col_lab[node] < 0)
					col_known.push_back(node);
				gen_col_lab[node] = lab;
			end else begin
				if (gen_row_lab[node] < 0)
					row_known.push_back(node);
				gen_row_lab[node] = lab;
			end
		end
		pending_items.push_back(it);
	endtask

	task automatic queue_add(int nr, int nc, int w);
		item_t it;
		it = random_item_bits();
		it.command = CMD_ADD;
		it.node_row = NODE_FW'(nr);
		it.node_col = NODE_FW'(nc);
		it.weight = WEIGHT_W'(w);
		pending_items.push_back(it);
	endtask

	task automatic queue_read(int cr, int cc);
		item_t it;
		it = random_item_bits();
		it.command = CMD_READ;
		it.cluster_row = LABEL_FW'(cr);
		it.cluster_col = LABEL_FW'(cc);
		pending_items.push_back(it);
	endtask

	task automatic queue_clear();
		item_t it;
		it = random_item_bits();
		it.command = CMD_CLEAR;
		pending_items.push_back(it);
	endtask

	// Mostly adds between labelled nodes, plus relabels, reads and rare clears
	task automatic queue_random_item();
		int roll;
		int k;
		int nr;
		int nc;
		int w;
		bit can_add;
		k = active_clusters();
		roll = $urandom_range(0, 999);
		can_add = row_known.size() != 0 &&
			(cfg_bip ? col_known.size() != 0 : 1'b1);
		if (roll < 5) begin
			queue_clear();
		end else if (roll >= 755) begin
			roll = $urandom_range(0, 99);
			if (roll < 45 && can_add) begin
				nr = row_known[$urandom_range(0, row_known.size() - 1)];
				if (cfg_bip)
					nc = gen_col_lab[col_known[$urandom_range(0, col_known.size() - 1)]];
				else
					nc = gen_row_lab[row_known[$urandom_range(0, row_known.size() - 1)]];
				queue_read(gen_row_lab[nr], nc);
			end else if (roll < 85 && k > 0) begin
				queue_read($urandom_range(0, k - 1), $urandom_range(0, k - 1));
			end else begin
				queue_read($urandom_range(0, 63), $urandom_range(0, 63));
			end
		end else if (roll >= 255 && can_add) begin
			nr = row_known[$urandom_range(0, row_known.size() - 1)];
			if (cfg_bip)
				nc = col_known[$urandom_range(0, col_known.size() - 1)];
			else
				nc = row_known[$urandom_range(0, row_known.size() - 1)];
			roll = $urandom_range(0, 99);
			if (roll < 10)
				w = 65535;
			else if (roll < 15)
				w = 0;
			else
				w = $urandom_range(0, 65535);
			queue_add(nr, nc, w);
		end else begin
			if ($urandom_range(0, 9) == 0)
				nr = $urandom_range(0, MAX_NODES - 1);
			else
				nr = node_pool[$urandom_range(0, node_pool.size() - 1)];
			if (k > 0 && $urandom_range(0, 99) < 88)
				w = $urandom_range(0, k - 1);
			else
				w = $urandom_range(0, 63);
			queue_label(nr, $urandom_range(0, 1), w);
		end
	endtask

	// Register write in setup and access phases; the register takes the value at the access edge
	task automatic cfg_write(logic reg_idx, int value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (reg_idx == REG_CLUSTER_COUNT)
			cfg_count = value[CNT_W-1:0];
		else
			cfg_bip = value[0];
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || item_valid || predicted_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("MISMATCH at %0t ns, result %0d: %s got 0x%0h, predicted 0x%0h",
				$time, results_seen, what, got, want);
	endtask

	function automatic bit sender_idles();
		case (idle_mode)
		IDLE_RX_HEAVY: return $urandom_range(0, 99) < 10;
		IDLE_TX_HEAVY: return $urandom_range(0, 99) < 87;
		default: return 1'b0;
		endcase
	endfunction

	function automatic bit receiver_idles();
		case (idle_mode)
		IDLE_RX_HEAVY: return $urandom_range(0, 99) < 87;
		IDLE_TX_HEAVY: return $urandom_range(0, 99) < 10;
		default: return 1'b0;
		endcase
	endfunction

	// Item driver: predict on each transfer, then offer the next pending item
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ch.ready) begin
				predicted_results.push_back(apply_to_block_sums(item_data));
				command_seen[item_data.command]++;
				accepted_count <= accepted_count + 1;
			end
			if (!item_valid || item_ch.ready) begin
				if (pending_items.size() != 0 && !sender_idles()) begin
					item_valid <= 1'b1;
					item_data <= pending_items.pop_front();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off once the run is well under way
	always @(posedge clk) begin
		if (!hold_used && accepted_count >= HOLD_AT) begin
			hold_left <= HOLD_CYCLES;
			hold_used <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Result monitor: compare each transfer with the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_ready && result_ch.valid) begin
				results_seen++;
				if (predicted_results.size() == 0) begin
					report_mismatch("unpredicted result, cell_sum", result_ch.data.cell_sum, 0);
				end else begin
					want = predicted_results.pop_front();
					if (result_ch.data.cell_sum !== want.cell_sum)
						report_mismatch("cell_sum", result_ch.data.cell_sum, want.cell_sum);
					if (result_ch.data.saturated !== want.saturated)
						report_mismatch("saturated", result_ch.data.saturated, want.saturated);
					if (result_ch.data.status !== want.status)
						report_mismatch("status", result_ch.data.status, want.status);
					status_seen[want.status]++;
					if (want.cell_sum > peak_sum)
						peak_sum = want.cell_sum;
				end
			end
			result_ready <= (hold_left == 0) && !receiver_idles();
		end
	end

	initial begin
		#4_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int ph;
		int k_set;
		bit bip_set;
		foreach (gen_row_lab[i]) begin
			gen_row_lab[i] = -1;
			gen_col_lab[i] = -1;
			row_labels[i] = '0;
			col_labels[i] = '0;
		end
		foreach (cell_sums[i])
			cell_sums[i] = '0;
		foreach (command_seen[i]) begin
			command_seen[i] = 0;
			status_seen[i] = 0;
		end
		node_pool.push_back(0);
		node_pool.push_back(MAX_NODES - 1);
		repeat (POOL_SIZE - 2)
			node_pool.push_back($urandom_range(0, MAX_NODES - 1));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: extreme nodes and labels, rejects, accumulation, clear
		cfg_write(REG_CLUSTER_COUNT, 40);
		cfg_write(REG_BIPARTITE, 1);
		queue_label(0, 1'b0, 0);
		queue_label(MAX_NODES - 1, 1'b0, 39);
		queue_label(MAX_NODES - 1, 1'b1, 0);
		queue_label(0, 1'b1, 39);
		queue_label(100, 1'b0, 40);
		queue_label(200, 1'b1, MAX_CLUSTERS - 1);
		queue_add(0, MAX_NODES - 1, 65535);
		queue_add(0, MAX_NODES - 1, 65535);
		queue_add(MAX_NODES - 1, 0, 0);
		queue_add(MAX_NODES - 1, 0, 1);
		queue_read(0, 0);
		queue_read(39, 39);
		queue_read(40, 0);
		queue_read(0, MAX_CLUSTERS - 1);
		queue_clear();
		queue_read(0, 0);
		wait_drained();

		// lowered count strands labels already written
		cfg_write(REG_CLUSTER_COUNT, 20);
		queue_add(MAX_NODES - 1, 0, 5);
		queue_read(19, 19);
		queue_read(20, 0);
		wait_drained();

		// shared table; a column label written now waits for bipartite mode
		cfg_write(REG_CLUSTER_COUNT, 64);
		cfg_write(REG_BIPARTITE, 0);
		queue_label(7, 1'b1, 5);
		queue_add(0, MAX_NODES - 1, 7);
		queue_add(0, 0, 65535);
		queue_read(0, 39);
		wait_drained();

		// Random phases over register settings and idle patterns
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
			0: begin k_set = 64; bip_set = 1'b1; end
			1: begin k_set = 64; bip_set = 1'b0; end
			2: begin k_set = 1; bip_set = 1'b1; end
			3: begin k_set = 17; bip_set = 1'b0; end
			4: begin k_set = 0; bip_set = 1'b1; end
			5: begin k_set = 100; bip_set = 1'b0; end
			6: begin k_set = 33; bip_set = 1'b1; end
			7: begin k_set = 127; bip_set = 1'b1; end
			default: begin k_set = 64; bip_set = 1'b0; end
			endcase
			if (ph < 3)
				idle_mode <= IDLE_RX_HEAVY;
			else if (ph < 6)
				idle_mode <= IDLE_TX_HEAVY;
			else
				idle_mode <= IDLE_NONE;
			cfg_write(REG_CLUSTER_COUNT, k_set);
			cfg_write(REG_BIPARTITE, bip_set);
			repeat (PHASE_ITEMS)
				queue_random_item();
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (predicted_results.size() != 0)
			report_mismatch("results never returned, count", predicted_results.size(), 0);
		$display("Run covered %0d transfers: %0d label sets, %0d adds, %0d reads, %0d clears",
			results_seen, command_seen[CMD_SET_LABEL], command_seen[CMD_ADD],
			command_seen[CMD_READ], command_seen[CMD_CLEAR]);
		$display("Outcomes: %0d ok, %0d label rejects, %0d read rejects; peak cell sum 0x%0h",
			status_seen[ST_OK], status_seen[ST_BAD_LABEL], status_seen[ST_BAD_READ], peak_sum);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
